// ===== rtl/lqc_pkg.sv =====
// package for the linear ticket queue: sizes, codes, request and result types
`default_nettype none

package lqc_pkg;

    localparam int DEPTH       = 8;
    localparam int TICKET_BITS = 16;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (TICKET_BITS < 16) ? TICKET_BITS : 16;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_PROCESS = 2'd1,
        ACT_CANCEL  = 2'd2,
        ACT_LIST    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_PROCESSED = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_LISTED    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DECODE,
        SEQ_SEARCH,
        SEQ_SHIFT,
        SEQ_LIST
    } seq_state_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] ticket;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] ticket_out;
        logic        last;
    } res_t;

endpackage : lqc_pkg

`default_nettype wire

// ===== rtl/linear_queue_with_cancel.sv =====
// linear ticket queue with cancel by value, one-slot-per-cycle sequencer
`default_nettype none
// sequence: add and process are latched, then the decode state loads their result register;
// list passes decode, then its list state loads each entry, one a cycle while results are taken;
// cancel checks one slot a cycle from head to the match and, on a match, shifts one slot
// a cycle to the tail before its result is loaded; a stalled result holds the sequencer
// requests: one at a time, s_ready high only while idle
// sync reset (aresetn low) empties the queue, drops any waiting result, leaves slots as is

module linear_queue_with_cancel (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lqc_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lqc_pkg::res_t      m_data
);
    import lqc_pkg::*;

    // sequencer and queue pointers
    seq_state_t state_reg, state_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // latched request
    action_t            act_reg;
    logic [STORE_W-1:0] tk_reg;

    // slot store: one read address, one write address per cycle
    logic [STORE_W-1:0] slots_reg [DEPTH];
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [STORE_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [STORE_W-1:0] rd_data;

    // result register
    logic m_valid_reg, m_valid_next;
    res_t m_data_reg, m_data_next;

    logic             out_free;
    logic             emit;
    res_t             emit_res;
    logic             q_empty;
    logic             q_full;
    logic [CNT_W-1:0] idx_plus;
    logic             at_end;
    logic             hit;

    assign s_ready = (state_reg == SEQ_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // result slot can take a new result when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    assign q_empty  = (head_reg >= fill_reg);
    assign q_full   = (fill_reg >= CNT_W'(DEPTH));
    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);
    assign at_end   = (idx_plus >= fill_reg);

    // shift reads the slot above the one being written
    assign rd_addr = (state_reg == SEQ_SHIFT) ? idx_plus[IDX_W-1:0] : idx_reg;
    assign rd_data = slots_reg[rd_addr];
    assign hit     = (rd_data == tk_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) state_next = SEQ_DECODE;
            end
            SEQ_DECODE: begin
                case (act_reg)
                    ACT_CANCEL: begin
                        if (!q_empty) state_next = SEQ_SEARCH;
                        else if (out_free) state_next = SEQ_IDLE;
                    end
                    ACT_LIST: begin
                        if (!q_empty) state_next = SEQ_LIST;
                        else if (out_free) state_next = SEQ_IDLE;
                    end
                    default: begin
                        if (out_free) state_next = SEQ_IDLE;
                    end
                endcase
            end
            SEQ_SEARCH: begin
                if (hit) state_next = SEQ_SHIFT;
                else if (at_end && out_free) state_next = SEQ_IDLE;
            end
            SEQ_SHIFT: begin
                if (at_end && out_free) state_next = SEQ_IDLE;
            end
            SEQ_LIST: begin
                if (at_end && out_free) state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        head_next           = head_reg;
        fill_next           = fill_reg;
        idx_next            = idx_reg;
        wr_en               = 1'b0;
        wr_addr             = idx_reg;
        wr_data             = rd_data;
        emit                = 1'b0;
        emit_res.status     = ST_EMPTY;
        emit_res.ticket_out = '0;
        emit_res.last       = 1'b1;

        case (state_reg)
            SEQ_IDLE: begin
                // walk always starts at the head
                idx_next = head_reg[IDX_W-1:0];
            end
            SEQ_DECODE: begin
                case (act_reg)
                    ACT_ADD: begin
                        emit = out_free;
                        if (q_full) begin
                            emit_res.status = ST_FULL;
                        end else begin
                            emit_res.status = ST_ADDED;
                            if (out_free) begin
                                wr_en     = 1'b1;
                                wr_addr   = fill_reg[IDX_W-1:0];
                                wr_data   = tk_reg;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                    end
                    ACT_PROCESS: begin
                        emit = out_free;
                        if (!q_empty) begin
                            // idx equals head here
                            emit_res.status     = ST_PROCESSED;
                            emit_res.ticket_out = 16'(rd_data);
                            if (out_free) head_next = head_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                        // cancel or list on an empty queue
                        emit = q_empty && out_free;
                    end
                endcase
            end
            SEQ_SEARCH: begin
                if (!hit) begin
                    if (at_end) begin
                        emit            = out_free;
                        emit_res.status = ST_NOT_FOUND;
                    end else begin
                        idx_next = idx_plus[IDX_W-1:0];
                    end
                end
            end
            SEQ_SHIFT: begin
                if (!at_end) begin
                    // move next entry down over the cancelled one
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_data  = rd_data;
                    idx_next = idx_plus[IDX_W-1:0];
                end else begin
                    emit            = out_free;
                    emit_res.status = ST_CANCELLED;
                    if (out_free) fill_next = fill_reg - CNT_W'(1);
                end
            end
            SEQ_LIST: begin
                emit                = out_free;
                emit_res.status     = ST_LISTED;
                emit_res.ticket_out = 16'(rd_data);
                emit_res.last       = at_end;
                if (out_free && !at_end) idx_next = idx_plus[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    // result register: load on emit, clear when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_valid && s_ready) begin
            act_reg <= s_data.action;
            tk_reg  <= s_data.ticket[STORE_W-1:0];
        end
        if (wr_en) slots_reg[wr_addr] <= wr_data;
    end

endmodule : linear_queue_with_cancel

`default_nettype wire
